FILE: hw/rtl/klex_pkg.sv
// Shared types, constants and helper functions of the keyword token lexer.
// No dependencies; every other file of the block uses it by scoped names.
package klex_pkg;

	// Counter and field widths
	localparam int POSITION_BITS = 32;
	localparam int LENGTH_BITS   = 16;
	localparam int START_W       = 32;
	localparam int LEN_W         = 16;
	localparam int LINE_W        = 32;
	localparam int PREFIX_W      = 48;
	localparam int KW_COUNT      = 6;

	// Largest token length: the smaller of the counter range and the field range
	localparam longint unsigned LEN_ALL  = (64'd1 << LENGTH_BITS) - 64'd1;
	localparam longint unsigned LEN_CAP  = (LEN_ALL < 64'd65535) ? LEN_ALL : 64'd65535;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = LENGTH_BITS'(LEN_CAP);
	localparam logic [LENGTH_BITS-1:0] LEN_TWO = (LEN_CAP < 64'd2) ? LEN_MAX : LENGTH_BITS'(2);

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_EQ    = 8'h3d;

	typedef enum logic [3:0] {
		KIND_IDENT  = 4'd0,
		KIND_NUMBER = 4'd1,
		KIND_PLUS   = 4'd2,
		KIND_SEMI   = 4'd3,
		KIND_ASSIGN = 4'd4,
		KIND_EQUALS = 4'd5,
		KIND_IF     = 4'd6,
		KIND_ELSE   = 4'd7,
		KIND_PRINT  = 4'd8,
		KIND_LET    = 4'd9,
		KIND_FUNC   = 4'd10,
		KIND_RETURN = 4'd11,
		KIND_BAD    = 4'd12
	} token_kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_NUMBER = 4'b0010,
		MODE_IDENT  = 4'b0100,
		MODE_EQUAL  = 4'b1000
	} scan_mode_t;

	// Keyword text, first character in the low byte
	localparam logic [PREFIX_W-1:0] KW_TEXT [KW_COUNT] = '{
		48'h0000_0000_6669,   // if
		48'h0000_6573_6c65,   // else
		48'h0074_6e69_7270,   // print
		48'h0000_0074_656c,   // let
		48'h0000_636e_7566,   // func
		48'h6e72_7574_6572    // return
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd5, 3'd3, 3'd4, 3'd6};
	localparam token_kind_t KW_KIND [KW_COUNT] = '{
		KIND_IF, KIND_ELSE, KIND_PRINT, KIND_LET, KIND_FUNC, KIND_RETURN
	};

	typedef struct packed {
		token_kind_t        kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic [LINE_W-1:0]  line;
		logic [7:0]         bad;
	} tok_t;

	// Up to two tokens caused by one source byte
	typedef struct packed {
		tok_t tok0;
		tok_t tok1;
		logic two;
	} tok_pair_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
	endfunction

	// Bytes above the length are always zero, so the whole prefix is compared
	function automatic token_kind_t ident_kind(input logic [LENGTH_BITS-1:0] len,
			input logic [PREFIX_W-1:0] prefix);
		token_kind_t k;
		k = KIND_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (len == LENGTH_BITS'(KW_LEN[i]) && prefix == KW_TEXT[i]) begin
				k = KW_KIND[i];
			end
		end
		return k;
	endfunction

endpackage

FILE: hw/rtl/klex_scan.sv
// Scanner state and the single-pass step logic that turns one byte into tokens.
// Depends on klex_pkg.
module klex_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            byte_s1,
	input  logic                  last_s1,
	input  logic                  cfg_we,
	input  logic                  cfg_first_line,
	output klex_pkg::tok_pair_t   pair,
	output logic                  any_tok
);

	klex_pkg::scan_mode_t                   mode_q, mode_after, mode_n;
	logic [klex_pkg::POSITION_BITS-1:0]     start_q, start_n, pos_q;
	logic [klex_pkg::LENGTH_BITS-1:0]       len_q, len_n;
	logic [klex_pkg::LINE_W-1:0]            line_q, line_n;
	logic [klex_pkg::PREFIX_W-1:0]          prefix_q, prefix_n;

	logic dig, alp, cont_num, cont_id, eq2, done;
	logic pre_v, own_v, post_v;
	klex_pkg::tok_t pre_tok, own_tok, post_tok;

	// Continue, close or open the pending token
	always_comb begin
		dig      = klex_pkg::is_digit(byte_s1);
		alp      = klex_pkg::is_alpha(byte_s1);
		cont_num = (mode_q == klex_pkg::MODE_NUMBER) && dig;
		cont_id  = (mode_q == klex_pkg::MODE_IDENT) && (dig || alp);
		eq2      = (mode_q == klex_pkg::MODE_EQUAL) && (byte_s1 == klex_pkg::CH_EQ);
		done     = cont_num || cont_id || eq2;
		pre_v    = eq2 || (!done && mode_q != klex_pkg::MODE_IDLE);

		// Token that closes the pending one
		pre_tok.start = klex_pkg::START_W'(start_q);
		pre_tok.line  = line_q;
		pre_tok.bad   = 8'd0;
		if (eq2) begin
			pre_tok.kind   = klex_pkg::KIND_EQUALS;
			pre_tok.length = klex_pkg::LEN_W'(klex_pkg::LEN_TWO);
		end else begin
			case (mode_q)
				klex_pkg::MODE_NUMBER: begin
					pre_tok.kind   = klex_pkg::KIND_NUMBER;
					pre_tok.length = klex_pkg::LEN_W'(len_q);
				end
				klex_pkg::MODE_IDENT: begin
					pre_tok.kind   = klex_pkg::ident_kind(len_q, prefix_q);
					pre_tok.length = klex_pkg::LEN_W'(len_q);
				end
				klex_pkg::MODE_EQUAL: begin
					pre_tok.kind   = klex_pkg::KIND_ASSIGN;
					pre_tok.length = klex_pkg::LEN_W'(1);
				end
				default: begin
					pre_tok.kind   = klex_pkg::KIND_IDENT;
					pre_tok.length = klex_pkg::LEN_W'(0);
				end
			endcase
		end

		// Grow a continued run, saturating the length
		mode_after = (cont_num || cont_id) ? mode_q : klex_pkg::MODE_IDLE;
		start_n    = start_q;
		len_n      = len_q;
		prefix_n   = prefix_q;
		line_n     = line_q;
		if (cont_num || cont_id) begin
			if (len_q < klex_pkg::LEN_MAX) begin
				len_n = len_q + 1'b1;
			end
		end
		if (cont_id) begin
			for (int i = 0; i < klex_pkg::PREFIX_W / 8; i++) begin
				if (len_q == klex_pkg::LENGTH_BITS'(i)) begin
					prefix_n[8*i +: 8] = byte_s1;
				end
			end
		end

		// Handle the byte on its own
		own_v        = 1'b0;
		own_tok.kind = klex_pkg::KIND_BAD;
		own_tok.start  = klex_pkg::START_W'(pos_q);
		own_tok.length = klex_pkg::LEN_W'(1);
		own_tok.line   = line_q;
		own_tok.bad    = 8'd0;
		if (!done) begin
			if (byte_s1 == klex_pkg::CH_SPACE || byte_s1 == klex_pkg::CH_TAB ||
					byte_s1 == klex_pkg::CH_CR) begin
				own_v = 1'b0;
			end else if (byte_s1 == klex_pkg::CH_LF) begin
				line_n = line_q + 1'b1;
			end else if (byte_s1 == klex_pkg::CH_PLUS) begin
				own_v        = 1'b1;
				own_tok.kind = klex_pkg::KIND_PLUS;
			end else if (byte_s1 == klex_pkg::CH_SEMI) begin
				own_v        = 1'b1;
				own_tok.kind = klex_pkg::KIND_SEMI;
			end else if (byte_s1 == klex_pkg::CH_EQ) begin
				mode_after = klex_pkg::MODE_EQUAL;
				start_n    = pos_q;
				len_n      = klex_pkg::LENGTH_BITS'(1);
			end else if (dig) begin
				mode_after = klex_pkg::MODE_NUMBER;
				start_n    = pos_q;
				len_n      = klex_pkg::LENGTH_BITS'(1);
			end else if (alp) begin
				mode_after = klex_pkg::MODE_IDENT;
				start_n    = pos_q;
				len_n      = klex_pkg::LENGTH_BITS'(1);
				prefix_n   = klex_pkg::PREFIX_W'(byte_s1);
			end else begin
				own_v       = 1'b1;
				own_tok.bad = byte_s1;
			end
		end

		// Flush whatever is still pending on the final byte
		post_v          = last_s1 && (mode_after != klex_pkg::MODE_IDLE);
		post_tok.start  = klex_pkg::START_W'(start_n);
		post_tok.line   = line_q;
		post_tok.bad    = 8'd0;
		post_tok.length = klex_pkg::LEN_W'(len_n);
		case (mode_after)
			klex_pkg::MODE_NUMBER: post_tok.kind = klex_pkg::KIND_NUMBER;
			klex_pkg::MODE_IDENT:  post_tok.kind = klex_pkg::ident_kind(len_n, prefix_n);
			klex_pkg::MODE_EQUAL: begin
				post_tok.kind   = klex_pkg::KIND_ASSIGN;
				post_tok.length = klex_pkg::LEN_W'(1);
			end
			default: post_tok.kind = klex_pkg::KIND_IDENT;
		endcase
		mode_n = last_s1 ? klex_pkg::MODE_IDLE : mode_after;

		// Pack the tokens in emission order
		pair.tok0 = pre_v ? pre_tok : (own_v ? own_tok : post_tok);
		pair.tok1 = own_v ? own_tok : post_tok;
		pair.two  = pre_v && (own_v || post_v);
		any_tok   = pre_v || own_v || post_v;
	end

	// Advance the scanner state once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= klex_pkg::MODE_IDLE;
			start_q  <= '0;
			len_q    <= '0;
			pos_q    <= '0;
			line_q   <= klex_pkg::LINE_W'(1);
			prefix_q <= '0;
		end else if (cfg_we) begin
			line_q <= klex_pkg::LINE_W'(cfg_first_line);
		end else if (step) begin
			mode_q   <= mode_n;
			start_q  <= start_n;
			len_q    <= len_n;
			pos_q    <= pos_q + 1'b1;
			line_q   <= line_n;
			prefix_q <= prefix_n;
		end
	end

`ifndef SYNTHESIS
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 && !cfg_we |=> mode_q == klex_pkg::MODE_IDLE)
		else $error("scanner not idle after final byte");
	a_line_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step && !cfg_we |=> $stable(line_q))
		else $error("line counter moved without a byte");
	a_pos_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step && !cfg_we |=> pos_q == $past(pos_q) + 1'b1)
		else $error("byte position did not advance");
`endif

endmodule

FILE: hw/rtl/klex_out.sv
// Result register holding the tokens of one byte and sending them one beat at a time.
// Depends on klex_pkg.
module klex_out (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  klex_pkg::tok_pair_t   pair,
	output logic                  free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output klex_pkg::tok_t        tok,
	output logic                  last
);

	klex_pkg::tok_pair_t pair_q;
	logic                valid_q;
	logic                idx_q;

	// Show the second slot once the first has gone
	assign tok       = idx_q ? pair_q.tok1 : pair_q.tok0;
	assign last      = idx_q || !pair_q.two;
	assign out_valid = valid_q;
	assign free      = !valid_q || (out_ready && last);

	// Control: refill when the final beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (free) begin
			valid_q <= load;
			idx_q   <= 1'b0;
		end else if (out_ready) begin
			idx_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			pair_q <= pair;
		end
	end

`ifndef SYNTHESIS
	a_idx_two: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && idx_q |-> pair_q.two)
		else $error("second slot shown for a single token");
`endif

endmodule

FILE: hw/rtl/keyword_token_lexer_core.sv
// Top level of the keyword token lexer: input register, scanner and result register.
// Depends on klex_pkg, klex_scan and klex_out.
//
// Usage:
//   Source bytes enter on the in channel (source_byte, end_of_text), one beat
//   per byte; end_of_text marks the final byte and flushes a pending token.
//   Tokens leave on the out channel, one beat per token; last_of_run marks the
//   final token caused by a byte. A byte causes zero, one or two tokens.
//   The cfg channel writes first_line and loads the line counter with it;
//   write it only while no byte is in flight. cfg_ready is always high.
//   A token is shown on the out channel once its byte has passed the input
//   register and the scanner into the result register.
//   Throughput is one byte per cycle while out_ready stays high; a byte
//   that causes two tokens holds the result register until its second token
//   leaves, which can stall input. The input and result registers each hold a
//   beat, so one more byte is taken while a token waits for the receiver.
//   When the receiver stalls, both registers fill and in_ready drops.
//   Reset clears the scanner to idle, the byte position to zero and the line
//   counter to one; no reset clearing pass is needed.
module keyword_token_lexer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  source_byte,
	input  logic        end_of_text,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        first_line,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_kind,
	output logic [31:0] token_start,
	output logic [15:0] token_length,
	output logic [31:0] line_number,
	output logic [7:0]  bad_character,
	output logic        last_of_run
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                adv;
	logic                any_tok;
	logic                free;
	logic                cfg_we;
	klex_pkg::tok_pair_t pair;
	klex_pkg::tok_t      tok;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;

	// Move the held byte on when its tokens have room
	assign adv      = valid_s1 && (free || !any_tok);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= source_byte;
			last_s1 <= end_of_text;
		end
	end

	klex_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (adv),
		.byte_s1        (byte_s1),
		.last_s1        (last_s1),
		.cfg_we         (cfg_we),
		.cfg_first_line (first_line),
		.pair           (pair),
		.any_tok        (any_tok)
	);

	klex_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && any_tok),
		.pair      (pair),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tok       (tok),
		.last      (last_of_run)
	);

	// Unpack the token beat
	assign token_kind    = tok.kind;
	assign token_start   = tok.start;
	assign token_length  = tok.length;
	assign line_number   = tok.line;
	assign bad_character = tok.bad;

`ifndef SYNTHESIS
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && last_of_run)
		else $error("second token of a byte did not follow");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind))
		else $error("stalled token beat was replaced");
`endif

endmodule
